@@ hw/rtl/length_prefixed_frame_deframer_defines.svh @@
// Assertion macros for the frame deframer.
// Build with NO_ASSERTIONS defined to leave every check out.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LPFD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LPFD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LPFD_ASSERT(label, clk, rst_n, prop, msg)

`define LPFD_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

@@ hw/rtl/lpfd_pkg.sv @@
`default_nettype none

package lpfd_pkg;

  localparam int unsigned MAX_FRAME_LIMIT_DEF = 65536;
  localparam int unsigned CFG_W = 17;
  localparam logic [CFG_W-1:0] MAX_FRAME_RESET = CFG_W'(64 * 1024);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // One result word as it leaves the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] frame_type;
    logic [7:0] payload_byte;
    logic       has_payload;
    logic       last_of_frame;
    logic       status;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/lpfd_parser.sv @@
`default_nettype none

module lpfd_parser #(
  parameter int unsigned MAX_FRAME_LIMIT = lpfd_pkg::MAX_FRAME_LIMIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire logic [7:0]                 rx_byte,
  input  wire logic [lpfd_pkg::CFG_W-1:0] max_frame_length,
  output lpfd_pkg::result_t               res
);

  localparam int unsigned LEFT_W = (MAX_FRAME_LIMIT > 2) ? $clog2(MAX_FRAME_LIMIT) : 1;
  localparam logic [31:0] LIMIT32 = 32'(MAX_FRAME_LIMIT);

  lpfd_pkg::phase_t    phase_r, phase_nxt;
  logic [1:0]          hc_r, hc_nxt;
  logic [23:0]         len_r, len_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic [7:0]          type_r, type_nxt;
  logic                failed_r, failed_nxt;

  logic [31:0] cfg_ext;
  logic [31:0] limit;
  logic [31:0] len_full;

  assign cfg_ext  = 32'(max_frame_length);
  assign limit    = (cfg_ext > LIMIT32) ? LIMIT32 : cfg_ext;
  assign len_full = {rx_byte, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= lpfd_pkg::PH_HEADER;
      hc_r     <= 2'd0;
      len_r    <= '0;
      left_r   <= '0;
      type_r   <= '0;
      failed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hc_r     <= hc_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      type_r   <= type_nxt;
      failed_r <= failed_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    hc_nxt     = hc_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    type_nxt   = type_r;
    failed_nxt = failed_r;
    res        = '0;

    if (fire && !failed_r) begin
      unique case (phase_r)
        lpfd_pkg::PH_TYPE: begin
          type_nxt = rx_byte;
          if (left_r == '0) begin
            res.valid         = 1'b1;
            res.frame_type    = rx_byte;
            res.last_of_frame = 1'b1;
            phase_nxt         = lpfd_pkg::PH_HEADER;
          end else begin
            phase_nxt = lpfd_pkg::PH_PAYLOAD;
          end
        end
        lpfd_pkg::PH_PAYLOAD: begin
          res.valid         = 1'b1;
          res.frame_type    = type_r;
          res.payload_byte  = rx_byte;
          res.has_payload   = 1'b1;
          res.last_of_frame = (left_r <= LEFT_W'(1));
          left_nxt          = left_r - LEFT_W'(1);
          if (left_r <= LEFT_W'(1)) begin
            phase_nxt = lpfd_pkg::PH_HEADER;
            left_nxt  = '0;
          end
        end
        lpfd_pkg::PH_HEADER: begin
          hc_nxt = hc_r + 2'd1;
          if (hc_r != 2'd3) begin
            len_nxt[{hc_r, 3'b000} +: 8] = rx_byte;
          end else begin
            // Fourth length byte: check the full length against the limit.
            len_nxt = '0;
            if (len_full == 32'd0 || len_full > limit) begin
              failed_nxt = 1'b1;
              left_nxt   = '0;
              res.valid  = 1'b1;
              res.status = 1'b1;
            end else begin
              left_nxt  = LEFT_W'(len_full - 32'd1);
              phase_nxt = lpfd_pkg::PH_TYPE;
            end
          end
        end
        default: begin
          phase_nxt = lpfd_pkg::PH_HEADER;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/length_prefixed_frame_deframer.sv @@
// Length-prefixed frame deframer. Takes one received byte per word, up to one
// word per clock cycle unless stalled. Each frame is a 4-byte little-endian
// length, a type byte and length-1 payload bytes; every payload byte comes out
// with its frame type and a last mark, and a frame without payload gives one
// empty word at its type byte. A length of zero or above the smaller of
// max_frame_length and MAX_FRAME_LIMIT gives one word with status set, after
// which all input is taken and dropped until reset. A byte waits in an input
// register while the parser works on it, and its result is caught in the output
// register. The input stalls only while a byte waits behind a result word that
// out_stall holds. Write max_frame_length only while idle.
`default_nettype none

`include "length_prefixed_frame_deframer_defines.svh"

module length_prefixed_frame_deframer #(
  parameter int unsigned MAX_FRAME_LIMIT = lpfd_pkg::MAX_FRAME_LIMIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_rx_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_frame_type,
  output logic [7:0]                      out_payload_byte,
  output logic                            out_has_payload,
  output logic                            out_last_of_frame,
  output logic                            out_status,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [lpfd_pkg::CFG_W-1:0] cfg_max_frame_length
);

  logic                       in_valid_r;
  logic [7:0]                 in_byte_r;
  logic [lpfd_pkg::CFG_W-1:0] max_len_r;
  logic                       out_valid_r;
  lpfd_pkg::result_t          res;
  lpfd_pkg::result_t          res_r;
  logic                       advance;
  logic                       fire;
  logic                       err_dirty;
  logic                       empty_unmarked;

  // The parser stage moves whenever the output register is free or draining.
  assign advance   = !(out_valid_r && out_stall);
  assign fire      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= lpfd_pkg::MAX_FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_frame_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  lpfd_parser #(
    .MAX_FRAME_LIMIT(MAX_FRAME_LIMIT)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .rx_byte         (in_byte_r),
    .max_frame_length(max_len_r),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_type    = res_r.frame_type;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_has_payload   = res_r.has_payload;
  assign out_last_of_frame = res_r.last_of_frame;
  assign out_status        = res_r.status;

  assign err_dirty = out_valid && out_status &&
                     (out_has_payload || out_last_of_frame ||
                      out_payload_byte != 8'd0 || out_frame_type != 8'd0);
  assign empty_unmarked = out_valid && !out_status && !out_has_payload && !out_last_of_frame;

  `LPFD_ASSERT_NEVER(a_err_fields_clear, clk, rst_n, err_dirty, "error word carries data")
  `LPFD_ASSERT_NEVER(a_empty_is_last, clk, rst_n, empty_unmarked, "empty word not marked last")
  `LPFD_ASSERT(a_word_src, clk, rst_n, $rose(out_valid) |-> $past(in_valid_r), "orphan result word")

endmodule

`default_nettype wire
